[src/empc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder move PI controller package
// Widths, register defaults, register indexes and sequencer states that are
// shared by the controller and its multiplier.
// ----------------------------------------------------------------------------
package empc_pkg;

    // Field and storage widths.
    localparam int COUNT_BITS    = 24;
    localparam int INTEGRAL_BITS = 48;
    localparam int FRAC_BITS     = 16;
    localparam int GAIN_BITS     = 16;
    localparam int LIMIT_BITS    = 7;
    localparam int POWER_BITS    = 8;
    localparam int TIME_BITS     = 32;

    // Stream payload layout.
    localparam int S_RAW_BITS  = 2 * COUNT_BITS + TIME_BITS;
    localparam int S_DATA_BITS = ((S_RAW_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = ((POWER_BITS + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // Datapath widths derived from the fields.
    localparam int ERR_BITS   = COUNT_BITS + 1;
    localparam int IHI_BITS   = INTEGRAL_BITS - FRAC_BITS;
    localparam int MUL_A_BITS = ((IHI_BITS > ERR_BITS) ? IHI_BITS : ERR_BITS) + 1;
    localparam int MUL_B_BITS = GAIN_BITS + 1;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
    localparam int H_EXP      = 40;
    localparam int H_BITS     = H_EXP + 2;
    localparam int TOT_BITS   = H_BITS + FRAC_BITS + 1;
    localparam int HSUM_BITS  = TOT_BITS + 1;
    localparam int SUM_BITS   = INTEGRAL_BITS + 2;
    localparam int QUOT_SHIFT = 2 * FRAC_BITS;
    localparam int QUOT_BITS  = TOT_BITS - QUOT_SHIFT;

    // Watchdog scaling: Q6.10 rate, rounded half up.
    localparam int WD_SHIFT = 10;
    localparam logic [WD_SHIFT-1:0] WD_ROUND = WD_SHIFT'(1) << (WD_SHIFT - 1);

    // Register reset values.
    localparam logic [GAIN_BITS-1:0]     PROP_GAIN_RST   = 16'd872;
    localparam logic [GAIN_BITS-1:0]     INTEG_GAIN_RST  = 16'd308;
    localparam logic [GAIN_BITS-1:0]     INTEG_DECAY_RST = 16'd59638;
    localparam logic [LIMIT_BITS-1:0]    POWER_LIMIT_RST = 7'd85;
    localparam logic [CFG_DATA_BITS-1:0] SETTLE_BAND_RST = 16'd200;
    localparam logic [CFG_DATA_BITS-1:0] SETTLE_MS_RST   = 16'd750;
    localparam logic [CFG_DATA_BITS-1:0] WD_RATE_RST     = 16'd1778;
    localparam logic [CFG_DATA_BITS-1:0] WD_BASE_RST     = 16'd2000;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_INTEG_GAIN  = 3'd1,
        CFG_INTEG_DECAY = 3'd2,
        CFG_POWER_LIMIT = 3'd3,
        CFG_SETTLE_BAND = 3'd4,
        CFG_SETTLE_MS   = 3'd5,
        CFG_WD_RATE     = 3'd6,
        CFG_WD_BASE     = 3'd7
    } cfg_idx_t;

    // Item action codes.
    localparam logic ACT_START  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_WD_MUL,
        ST_WD_FIN,
        ST_LK_HI,
        ST_LK_LO,
        ST_LK_ADD,
        ST_LK_SAT,
        ST_PW_H,
        ST_PW_P,
        ST_PW_SUM,
        ST_PW_TOT,
        ST_PW_OUT,
        ST_DONE
    } ctl_state_t;

endpackage

[src/empc_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared signed multiplier
// One registered signed multiply, loaded when enabled and reused by every
// product the controller needs.
// ----------------------------------------------------------------------------
module empc_mul
    import empc_pkg::*;
(
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [MUL_A_BITS-1:0] a,
    input  logic signed [MUL_B_BITS-1:0] b,
    output logic signed [PROD_BITS-1:0]  prod
);

    logic signed [PROD_BITS-1:0] prod_reg;

    // Product register; holds its value between loads.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_BITS'(a) * PROD_BITS'(b);
        end
    end

    assign prod = prod_reg;

endmodule

[src/encoder_move_pi_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder move PI controller
// Drives an encoder to a relative target with a PI loop over a leaky
// integral, with settle detection and a distance-scaled watchdog.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                Payload
//  s_*      in         s_tvalid / s_tready      tdata: target, encoder, now_ms
//                                               tuser: action
//  m_*      out        m_tvalid / m_tready      tdata: drive_power
//                                               tlast: finished, tuser: succeeded
//  cfg_*    in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
//  A start beat passes ST_PREP, ST_WD_MUL and ST_WD_FIN before ST_DONE, a sample
//  while idle goes from ST_PREP straight to ST_DONE, and a sample during a move
//  runs the leak and power states, whose five products share the one multiplier.
//  A new beat is taken in the cycle after a result is loaded into the output
//  register, while that result may still wait for m_tready.
//  If the output register is still full, the sequencer holds its result.
//  Reset (rst_n low) ends any move, empties the output and restores the
//  register defaults. cfg_ready is always high.
// ----------------------------------------------------------------------------
module encoder_move_pi_controller
    import empc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      s_tvalid,
    output logic                      s_tready,
    // [23:0] target_count, [47:24] enc_value, [79:48] now_ms
    input  logic [S_DATA_BITS-1:0]    s_tdata,
    // [0] action
    input  logic                      s_tuser,

    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [7:0] drive_power
    output logic [M_DATA_BITS-1:0]    m_tdata,
    output logic                      m_tlast,
    // [0] succeeded
    output logic                      m_tuser,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    // Configuration registers.
    logic [GAIN_BITS-1:0]     prop_gain_reg;
    logic [GAIN_BITS-1:0]     integ_gain_reg;
    logic [GAIN_BITS-1:0]     integ_decay_reg;
    logic [LIMIT_BITS-1:0]    power_limit_reg;
    logic [CFG_DATA_BITS-1:0] settle_band_reg;
    logic [CFG_DATA_BITS-1:0] settle_ms_reg;
    logic [CFG_DATA_BITS-1:0] wd_rate_reg;
    logic [CFG_DATA_BITS-1:0] wd_base_reg;

    // Control state.
    ctl_state_t state_reg, state_next;
    logic       move_active_reg, move_active_next;
    logic       in_band_reg, in_band_next;
    logic       m_tvalid_reg, m_tvalid_next;

    // Latched input beat.
    logic                         in_action_reg, in_action_next;
    logic signed [COUNT_BITS-1:0] in_target_reg, in_target_next;
    logic [COUNT_BITS-1:0]        in_count_reg, in_count_next;
    logic [TIME_BITS-1:0]         in_now_reg, in_now_next;

    // Move state.
    logic [COUNT_BITS-1:0]           start_count_reg, start_count_next;
    logic signed [COUNT_BITS-1:0]    goal_count_reg, goal_count_next;
    logic [TIME_BITS-1:0]            start_time_reg, start_time_next;
    logic [TIME_BITS-1:0]            wd_limit_reg, wd_limit_next;
    logic [TIME_BITS-1:0]            band_enter_reg, band_enter_next;
    logic signed [INTEGRAL_BITS-1:0] integral_reg, integral_next;

    // Working registers.
    logic signed [ERR_BITS-1:0] err_reg, err_next;
    logic [INTEGRAL_BITS-1:0]   imag_reg, imag_next;
    logic                       ineg_reg, ineg_next;
    logic signed [TOT_BITS-1:0] acc_reg, acc_next;

    // Pending result and output register.
    logic [POWER_BITS-1:0]  res_power_reg, res_power_next;
    logic                   res_fin_reg, res_fin_next;
    logic                   res_ok_reg, res_ok_next;
    logic [M_DATA_BITS-1:0] m_tdata_reg, m_tdata_next;
    logic                   m_tlast_reg, m_tlast_next;
    logic                   m_tuser_reg, m_tuser_next;

    // Multiplier interface.
    logic                         mul_en;
    logic signed [MUL_A_BITS-1:0] mul_a;
    logic signed [MUL_B_BITS-1:0] mul_b;
    logic signed [PROD_BITS-1:0]  prod;

    // Datapath terms.
    logic signed [COUNT_BITS-1:0]    pos;
    logic signed [ERR_BITS-1:0]      err_calc;
    logic [COUNT_BITS-1:0]           target_mag;
    logic [INTEGRAL_BITS-1:0]        integ_mag;
    logic signed [SUM_BITS-1:0]      err_shift;
    logic signed [SUM_BITS-1:0]      scaled;
    logic signed [SUM_BITS-1:0]      leak_sum;
    logic                            leak_ovf;
    logic signed [INTEGRAL_BITS-1:0] leak_sat;
    logic signed [IHI_BITS-1:0]      integ_hi;
    logic signed [HSUM_BITS-1:0]     h_sum;
    logic signed [HSUM_BITS-1:0]     h_max;
    logic signed [HSUM_BITS-1:0]     h_min;
    logic signed [TOT_BITS-1:0]      h_clamped;
    logic [PROD_BITS-1:0]            wd_sum;
    logic                            tot_neg;
    logic [TOT_BITS-1:0]             tot_mag;
    logic [QUOT_BITS-1:0]            q_mag;
    logic [LIMIT_BITS-1:0]           pow_mag;
    logic [POWER_BITS-1:0]           power;
    logic [ERR_BITS-1:0]             err_mag;
    logic                            band_ok;
    logic [TIME_BITS-1:0]            enter_time;
    logic [TIME_BITS-1:0]            band_elapsed;
    logic [TIME_BITS-1:0]            move_elapsed;
    logic                            settled;
    logic                            timed_out;
    logic                            finish;

    empc_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tlast   = m_tlast_reg;
    assign m_tuser   = m_tuser_reg;

    // Position error relative to the move start, and the two magnitudes.
    assign pos        = in_count_reg - start_count_reg;
    assign err_calc   = ERR_BITS'(pos) - ERR_BITS'(goal_count_reg);
    assign target_mag = in_target_reg[COUNT_BITS-1] ? COUNT_BITS'(-in_target_reg)
                                                    : COUNT_BITS'(in_target_reg);
    assign integ_mag  = integral_reg[INTEGRAL_BITS-1] ? INTEGRAL_BITS'(-integral_reg)
                                                      : INTEGRAL_BITS'(integral_reg);

    // Leaky integral: add the error to the signed decayed value and saturate.
    assign err_shift = SUM_BITS'(err_reg) <<< FRAC_BITS;
    assign scaled    = $signed(SUM_BITS'(acc_reg[INTEGRAL_BITS-1:0]));
    assign leak_sum  = ineg_reg ? (err_shift - scaled) : (err_shift + scaled);
    assign leak_ovf  = (leak_sum[SUM_BITS-1:INTEGRAL_BITS-1] != '0)
                    && (leak_sum[SUM_BITS-1:INTEGRAL_BITS-1] != '1);
    assign leak_sat  = leak_ovf ? (leak_sum[SUM_BITS-1]
                                   ? $signed({1'b1, {(INTEGRAL_BITS-1){1'b0}}})
                                   : $signed({1'b0, {(INTEGRAL_BITS-1){1'b1}}}))
                                : leak_sum[INTEGRAL_BITS-1:0];

    // Integer part of the integral and the clamped high sum of the PI terms.
    assign integ_hi  = integral_reg[INTEGRAL_BITS-1:FRAC_BITS];
    assign h_max     = HSUM_BITS'(1) <<< H_EXP;
    assign h_min     = -h_max;
    assign h_sum     = HSUM_BITS'(acc_reg) + HSUM_BITS'(prod);
    assign h_clamped = (h_sum > h_max) ? TOT_BITS'(h_max)
                     : (h_sum < h_min) ? TOT_BITS'(h_min)
                     : TOT_BITS'(h_sum);

    // Watchdog limit: rounded scaled distance plus the base time.
    assign wd_sum = $unsigned(prod) + PROD_BITS'({wd_base_reg, WD_ROUND});

    // Power: truncate toward zero, then clamp to the limit.
    assign tot_neg = acc_reg[TOT_BITS-1];
    assign tot_mag = tot_neg ? TOT_BITS'(-acc_reg) : TOT_BITS'(acc_reg);
    assign q_mag   = tot_mag[TOT_BITS-1:QUOT_SHIFT];
    assign pow_mag = (q_mag > QUOT_BITS'(power_limit_reg)) ? power_limit_reg
                                                           : q_mag[LIMIT_BITS-1:0];
    assign power   = tot_neg ? (POWER_BITS'(0) - POWER_BITS'(pow_mag))
                             : POWER_BITS'(pow_mag);

    // Settle band and watchdog decisions.
    assign err_mag      = err_reg[ERR_BITS-1] ? ERR_BITS'(-err_reg) : ERR_BITS'(err_reg);
    assign band_ok      = err_mag < ERR_BITS'(settle_band_reg);
    assign enter_time   = (band_ok && !in_band_reg) ? in_now_reg : band_enter_reg;
    assign band_elapsed = in_now_reg - enter_time;
    assign move_elapsed = in_now_reg - start_time_reg;
    assign settled      = band_ok && (band_elapsed > TIME_BITS'(settle_ms_reg));
    assign timed_out    = !band_ok && (move_elapsed > wd_limit_reg);
    assign finish       = settled || timed_out;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg   <= PROP_GAIN_RST;
            integ_gain_reg  <= INTEG_GAIN_RST;
            integ_decay_reg <= INTEG_DECAY_RST;
            power_limit_reg <= POWER_LIMIT_RST;
            settle_band_reg <= SETTLE_BAND_RST;
            settle_ms_reg   <= SETTLE_MS_RST;
            wd_rate_reg     <= WD_RATE_RST;
            wd_base_reg     <= WD_BASE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PROP_GAIN:   prop_gain_reg   <= cfg_data;
                CFG_INTEG_GAIN:  integ_gain_reg  <= cfg_data;
                CFG_INTEG_DECAY: integ_decay_reg <= cfg_data;
                CFG_POWER_LIMIT: power_limit_reg <= cfg_data[LIMIT_BITS-1:0];
                CFG_SETTLE_BAND: settle_band_reg <= cfg_data;
                CFG_SETTLE_MS:   settle_ms_reg   <= cfg_data;
                CFG_WD_RATE:     wd_rate_reg     <= cfg_data;
                CFG_WD_BASE:     wd_base_reg     <= cfg_data;
            endcase
        end
    end

    // Sequencer: next state, multiplier operands and register updates.
    always_comb
    begin
        state_next       = state_reg;
        move_active_next = move_active_reg;
        in_band_next     = in_band_reg;
        m_tvalid_next    = m_tvalid_reg;
        in_action_next   = in_action_reg;
        in_target_next   = in_target_reg;
        in_count_next    = in_count_reg;
        in_now_next      = in_now_reg;
        start_count_next = start_count_reg;
        goal_count_next  = goal_count_reg;
        start_time_next  = start_time_reg;
        wd_limit_next    = wd_limit_reg;
        band_enter_next  = band_enter_reg;
        integral_next    = integral_reg;
        err_next         = err_reg;
        imag_next        = imag_reg;
        ineg_next        = ineg_reg;
        acc_next         = acc_reg;
        res_power_next   = res_power_reg;
        res_fin_next     = res_fin_reg;
        res_ok_next      = res_ok_reg;
        m_tdata_next     = m_tdata_reg;
        m_tlast_next     = m_tlast_reg;
        m_tuser_next     = m_tuser_reg;
        mul_en           = 1'b0;
        mul_a            = '0;
        mul_b            = '0;

        // The output beat leaves when the consumer takes it.
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    in_action_next = s_tuser;
                    in_target_next = s_tdata[COUNT_BITS-1:0];
                    in_count_next  = s_tdata[2*COUNT_BITS-1:COUNT_BITS];
                    in_now_next    = s_tdata[2*COUNT_BITS +: TIME_BITS];
                    state_next     = ST_PREP;
                end
            end

            ST_PREP:
            begin
                if (in_action_reg == ACT_START)
                begin
                    goal_count_next  = in_target_reg;
                    start_count_next = in_count_reg;
                    start_time_next  = in_now_reg;
                    band_enter_next  = in_now_reg;
                    integral_next    = '0;
                    in_band_next     = 1'b0;
                    move_active_next = 1'b1;
                    imag_next        = INTEGRAL_BITS'(target_mag);
                    state_next       = ST_WD_MUL;
                end
                else if (move_active_reg)
                begin
                    err_next   = err_calc;
                    imag_next  = integ_mag;
                    ineg_next  = integral_reg[INTEGRAL_BITS-1];
                    state_next = ST_LK_HI;
                end
                else
                begin
                    res_power_next = '0;
                    res_fin_next   = 1'b0;
                    res_ok_next    = 1'b0;
                    state_next     = ST_DONE;
                end
            end

            ST_WD_MUL:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_BITS'(imag_reg[COUNT_BITS-1:0]);
                mul_b      = MUL_B_BITS'(wd_rate_reg);
                state_next = ST_WD_FIN;
            end

            ST_WD_FIN:
            begin
                wd_limit_next  = wd_sum[WD_SHIFT +: TIME_BITS];
                res_power_next = '0;
                res_fin_next   = 1'b0;
                res_ok_next    = 1'b0;
                state_next     = ST_DONE;
            end

            ST_LK_HI:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_BITS'(imag_reg[INTEGRAL_BITS-1:FRAC_BITS]);
                mul_b      = MUL_B_BITS'(integ_decay_reg);
                state_next = ST_LK_LO;
            end

            ST_LK_LO:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_BITS'(imag_reg[FRAC_BITS-1:0]);
                mul_b      = MUL_B_BITS'(integ_decay_reg);
                acc_next   = TOT_BITS'(prod);
                state_next = ST_LK_ADD;
            end

            ST_LK_ADD:
            begin
                acc_next   = acc_reg + $signed(TOT_BITS'(prod[PROD_BITS-1:FRAC_BITS]));
                state_next = ST_LK_SAT;
            end

            ST_LK_SAT:
            begin
                integral_next = leak_sat;
                state_next    = ST_PW_H;
            end

            ST_PW_H:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_BITS'(integ_hi);
                mul_b      = MUL_B_BITS'(integ_gain_reg);
                state_next = ST_PW_P;
            end

            ST_PW_P:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_BITS'(err_reg);
                mul_b      = MUL_B_BITS'(prop_gain_reg);
                acc_next   = TOT_BITS'(prod);
                state_next = ST_PW_SUM;
            end

            ST_PW_SUM:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_BITS'(integral_reg[FRAC_BITS-1:0]);
                mul_b      = MUL_B_BITS'(integ_gain_reg);
                acc_next   = h_clamped;
                state_next = ST_PW_TOT;
            end

            ST_PW_TOT:
            begin
                acc_next   = (acc_reg <<< FRAC_BITS) + TOT_BITS'(prod);
                state_next = ST_PW_OUT;
            end

            ST_PW_OUT:
            begin
                in_band_next     = band_ok;
                band_enter_next  = enter_time;
                move_active_next = !finish;
                res_power_next   = finish ? '0 : power;
                res_fin_next     = finish;
                res_ok_next      = settled;
                state_next       = ST_DONE;
            end

            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_DATA_BITS'(res_power_reg);
                    m_tlast_next  = res_fin_reg;
                    m_tuser_next  = res_ok_reg;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            move_active_reg <= 1'b0;
            in_band_reg     <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            move_active_reg <= move_active_next;
            in_band_reg     <= in_band_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        in_action_reg   <= in_action_next;
        in_target_reg   <= in_target_next;
        in_count_reg    <= in_count_next;
        in_now_reg      <= in_now_next;
        start_count_reg <= start_count_next;
        goal_count_reg  <= goal_count_next;
        start_time_reg  <= start_time_next;
        wd_limit_reg    <= wd_limit_next;
        band_enter_reg  <= band_enter_next;
        integral_reg    <= integral_next;
        err_reg         <= err_next;
        imag_reg        <= imag_next;
        ineg_reg        <= ineg_next;
        acc_reg         <= acc_next;
        res_power_reg   <= res_power_next;
        res_fin_reg     <= res_fin_next;
        res_ok_reg      <= res_ok_next;
        m_tdata_reg     <= m_tdata_next;
        m_tlast_reg     <= m_tlast_next;
        m_tuser_reg     <= m_tuser_next;
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder move PI controller testbench
// Sends start and sample beats through the controller under several register
// settings and idle patterns. A model kept inside the bench follows each move
// and predicts every drive command, which is then checked field by field.
// ----------------------------------------------------------------------------
module testbench;
    import empc_pkg::*;

    // Cycles with no beat moving on any channel before the run is abandoned.
    localparam int STALL_LIMIT = 4000;
    // Quiet cycles after the last result before registers change or the run ends.
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_BEATS = 150;
    localparam longint INTEG_MAX = (longint'(1) <<< (INTEGRAL_BITS - 1)) - 1;

    typedef struct packed {
        logic signed [POWER_BITS-1:0] power;
        logic                         finished;
        logic                         succeeded;
    } drive_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [S_DATA_BITS-1:0]    s_tdata = '0;
    logic                      s_tuser = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [M_DATA_BITS-1:0]    m_tdata;
    logic                      m_tlast;
    logic                      m_tuser;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    // Register copies as the block should hold them.
    logic [GAIN_BITS-1:0]     kp       = PROP_GAIN_RST;
    logic [GAIN_BITS-1:0]     ki       = INTEG_GAIN_RST;
    logic [GAIN_BITS-1:0]     decay    = INTEG_DECAY_RST;
    logic [LIMIT_BITS-1:0]    pwr_lim  = POWER_LIMIT_RST;
    logic [CFG_DATA_BITS-1:0] band     = SETTLE_BAND_RST;
    logic [CFG_DATA_BITS-1:0] settle   = SETTLE_MS_RST;
    logic [CFG_DATA_BITS-1:0] wd_rate  = WD_RATE_RST;
    logic [CFG_DATA_BITS-1:0] wd_base  = WD_BASE_RST;

    // Move state as the block should hold it.
    logic                         mv_active   = 1'b0;
    logic signed [COUNT_BITS-1:0] mv_origin   = '0;
    logic signed [COUNT_BITS-1:0] mv_goal     = '0;
    longint                       mv_integral = 0;
    logic [TIME_BITS-1:0]         mv_start_ms = '0;
    logic [TIME_BITS-1:0]         mv_wd_limit = '0;
    logic                         mv_in_band  = 1'b0;
    logic [TIME_BITS-1:0]         mv_band_ms  = '0;

    drive_result_t        pending_drive[$];
    int                   error_count   = 0;
    int                   beats_sent    = 0;
    int                   snd_idle_pct  = 0;
    int                   rcv_stall_pct = 0;
    int                   hold_left     = 0;
    int                   quiet_cycles  = 0;
    logic [TIME_BITS-1:0] wall_ms       = '0;

    encoder_move_pi_controller u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Clamp a value to plus or minus a magnitude.
    function automatic longint clamp_mag(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // Advance the move state by one accepted beat and return its drive command.
    function automatic drive_result_t predict_drive(input logic act,
                                                    input logic signed [COUNT_BITS-1:0] tgt,
                                                    input logic signed [COUNT_BITS-1:0] enc,
                                                    input logic [TIME_BITS-1:0] now);
        drive_result_t                res;
        logic signed [COUNT_BITS-1:0] pos;
        logic [TIME_BITS-1:0]         band_age, move_age;
        longint                       span, err, mag, scaled, acc, hi_part, lo_part, h, total, q;
        res = '0;
        if (act == ACT_START)
        begin
            span = longint'(tgt);
            if (span < 0)
                span = -span;
            mv_goal     = tgt;
            mv_origin   = enc;
            mv_start_ms = now;
            mv_band_ms  = now;
            mv_wd_limit = TIME_BITS'(((span * longint'(wd_rate) + 512) >>> WD_SHIFT)
                                     + longint'(wd_base));
            mv_integral = 0;
            mv_in_band  = 1'b0;
            mv_active   = 1'b1;
        end
        else if (mv_active)
        begin
            // Position wraps at the count width, the error itself does not.
            pos = enc - mv_origin;
            err = longint'(pos) - longint'(mv_goal);

            // Leaky integral: scale the magnitude, truncate toward zero, saturate.
            mag = (mv_integral < 0) ? -mv_integral : mv_integral;
            scaled = (mag >>> FRAC_BITS) * longint'(decay)
                     + (((mag % 65536) * longint'(decay)) >>> FRAC_BITS);
            acc = (mv_integral < 0) ? -scaled : scaled;
            acc = acc + err * 65536;
            if (acc > INTEG_MAX)
                acc = INTEG_MAX;
            else if (acc < -INTEG_MAX - 1)
                acc = -INTEG_MAX - 1;
            mv_integral = acc;

            // PI sum with the integral split into whole and fraction parts.
            hi_part = mv_integral >>> FRAC_BITS;
            lo_part = mv_integral - hi_part * 65536;
            h = clamp_mag(longint'(ki) * hi_part, longint'(1) <<< 60);
            h = clamp_mag(h + longint'(kp) * err, longint'(1) <<< H_EXP);
            total = h * 65536 + longint'(ki) * lo_part;
            q = (total < 0) ? -((-total) >>> 32) : (total >>> 32);
            q = clamp_mag(q, longint'(pwr_lim));

            // Settle band and watchdog.
            mag = (err < 0) ? -err : err;
            if (mag < longint'(band))
            begin
                if (!mv_in_band)
                    mv_band_ms = now;
                mv_in_band = 1'b1;
            end
            else
                mv_in_band = 1'b0;
            band_age = now - mv_band_ms;
            move_age = now - mv_start_ms;
            if (mv_in_band && band_age > TIME_BITS'(settle))
            begin
                res.finished  = 1'b1;
                res.succeeded = 1'b1;
            end
            else if (!mv_in_band && move_age > mv_wd_limit)
                res.finished = 1'b1;
            if (res.finished)
            begin
                q = 0;
                mv_active = 1'b0;
            end
            res.power = q[POWER_BITS-1:0];
        end
        return res;
    endfunction

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    // Compare every result beat with the oldest predicted drive command.
    always @(posedge clk)
    begin : check_drive
        drive_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_drive.size() == 0)
            begin
                $error("result beat arrived with no drive command expected");
                error_count++;
            end
            else
            begin
                want = pending_drive.pop_front();
                if (m_tdata[POWER_BITS-1:0] !== want.power)
                begin
                    $error("drive_power expected %0d got %0d",
                           $signed(want.power), $signed(m_tdata[POWER_BITS-1:0]));
                    error_count++;
                end
                if (m_tlast !== want.finished)
                begin
                    $error("finished expected %0b got %0b", want.finished, m_tlast);
                    error_count++;
                end
                if (m_tuser !== want.succeeded)
                begin
                    $error("succeeded expected %0b got %0b", want.succeeded, m_tuser);
                    error_count++;
                end
            end
        end
    end

    // Give up when no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("encoder_move_pi_controller: mismatch");
            $finish;
        end
    end

    task automatic set_idling(input int snd_pct, input int rcv_pct);
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
    endtask

    // Offer one beat, wait for it to be taken, and record its drive command.
    // Valid stays high on return so the next beat can follow without a gap.
    task automatic send_beat(input logic act, input logic [COUNT_BITS-1:0] tgt,
                             input logic [COUNT_BITS-1:0] enc,
                             input logic [TIME_BITS-1:0] now);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= S_DATA_BITS'({now, enc, tgt});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_drive.push_back(predict_drive(act, tgt, enc, now));
        beats_sent++;
    endtask

    // Stop offering beats and wait until every expected result is back.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_PROP_GAIN:   kp      = val;
            CFG_INTEG_GAIN:  ki      = val;
            CFG_INTEG_DECAY: decay   = val;
            CFG_POWER_LIMIT: pwr_lim = val[LIMIT_BITS-1:0];
            CFG_SETTLE_BAND: band    = val;
            CFG_SETTLE_MS:   settle  = val;
            CFG_WD_RATE:     wd_rate = val;
            CFG_WD_BASE:     wd_base = val;
            default:         ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Write the whole register set once the block has gone quiet.
    task automatic load_config(input logic [15:0] p_gain, input logic [15:0] i_gain,
                               input logic [15:0] i_decay, input logic [15:0] lim,
                               input logic [15:0] s_band, input logic [15:0] s_ms,
                               input logic [15:0] w_rate, input logic [15:0] w_base);
        wait_drain();
        write_reg(CFG_PROP_GAIN, p_gain);
        write_reg(CFG_INTEG_GAIN, i_gain);
        write_reg(CFG_INTEG_DECAY, i_decay);
        write_reg(CFG_POWER_LIMIT, lim);
        write_reg(CFG_SETTLE_BAND, s_band);
        write_reg(CFG_SETTLE_MS, s_ms);
        write_reg(CFG_WD_RATE, w_rate);
        write_reg(CFG_WD_BASE, w_base);
    endtask

    // Mostly a tuning that lets moves settle or time out in a few dozen
    // samples, sometimes anything at all.
    task automatic random_config();
        if ($urandom_range(3) == 0)
            load_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        else
            load_config(16'($urandom_range(0, 4000)), 16'($urandom_range(0, 1500)),
                        16'($urandom_range(50000, 65535)), 16'($urandom_range(0, 127)),
                        16'($urandom_range(0, 600)), 16'($urandom_range(0, 1500)),
                        16'($urandom_range(0, 4000)), 16'($urandom_range(0, 4000)));
    endtask

    // A beat with every field random, the action included.
    task automatic send_noise();
        send_beat(1'($urandom_range(1)), COUNT_BITS'($urandom), COUNT_BITS'($urandom),
                  $urandom);
    endtask

    // One move: a start, then samples whose position converges on the goal,
    // stays stuck, or wanders, with noise beats mixed in now and then.
    task automatic run_move();
        logic signed [COUNT_BITS-1:0] goal, origin;
        longint                       pos;
        int                           samples, style, gap_max, k;
        case ($urandom_range(9))
            0:       goal = COUNT_BITS'($urandom);
            1, 2:    goal = COUNT_BITS'(int'($urandom_range(0, 300)) - 150);
            default: goal = COUNT_BITS'(int'($urandom_range(0, 40000)) - 20000);
        endcase
        origin  = COUNT_BITS'($urandom);
        style   = $urandom_range(9);
        samples = ($urandom_range(19) == 0) ? 150 : $urandom_range(3, 40);
        case ($urandom_range(2))
            0:       gap_max = 2;
            1:       gap_max = 60;
            default: gap_max = 400;
        endcase
        // Occasionally jump the clock, so that time differences wrap.
        if ($urandom_range(7) == 0)
            wall_ms = $urandom;
        send_beat(ACT_START, goal, origin, wall_ms);
        pos = 0;
        for (k = 0; k < samples; k++)
        begin
            wall_ms += $urandom_range(0, gap_max);
            if (style <= 6)
                pos = pos + (longint'(goal) - pos) / longint'($urandom_range(1, 4))
                      + longint'(int'($urandom_range(0, 20)) - 10);
            else if (style <= 8)
                pos = longint'(int'($urandom_range(0, 20)) - 10);
            else
                pos = longint'($urandom);
            send_beat(ACT_SAMPLE, COUNT_BITS'($urandom),
                      COUNT_BITS'(longint'(origin) + pos), wall_ms);
            if ($urandom_range(29) == 0)
                send_noise();
        end
    endtask

    // Reset defaults: idle sample, restart, full-scale error, wrapped
    // position and time, a settled finish and a watchdog finish.
    task automatic test_directed();
        set_idling(0, 0);
        send_beat(ACT_SAMPLE, 24'h7FFFFF, 24'h800000, 32'hFFFF_FFFF);
        send_beat(ACT_START, 24'd1000, 24'h800000, 32'hFFFF_FF00);
        send_beat(ACT_SAMPLE, 24'h000000, 24'h800000, 32'hFFFF_FF02);
        send_beat(ACT_SAMPLE, 24'hFFFFFF, 24'h8001F4, 32'h0000_0040);
        // Restart while the first move is still running.
        send_beat(ACT_START, 24'h800000, 24'h7FFFFF, 32'd0);
        send_beat(ACT_SAMPLE, 24'h000000, 24'h7FFFFF, 32'd10);
        send_beat(ACT_SAMPLE, 24'h000000, 24'hFFFFFF, 32'd20);
        send_beat(ACT_SAMPLE, 24'h000000, 24'hFFFFFF, 32'd771);
        send_beat(ACT_SAMPLE, 24'h000000, 24'h123456, 32'd800);
        // Zero target: the watchdog limit is just the base.
        send_beat(ACT_START, 24'd0, 24'd0, 32'd1000);
        send_beat(ACT_SAMPLE, 24'd0, 24'd199, 32'd1500);
        send_beat(ACT_SAMPLE, 24'd0, 24'd300, 32'd3000);
        send_beat(ACT_SAMPLE, 24'd0, 24'd300, 32'd3001);
        send_beat(ACT_SAMPLE, 24'd0, 24'd300, 32'd3002);
        wait_drain();
    endtask

    // All registers at their top, then all at zero.
    task automatic test_register_extremes();
        int k;
        set_idling(0, 0);
        // Power limit written with its unused upper bits set.
        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // A stuck full-scale move drives the integral into saturation.
        send_beat(ACT_START, 24'h7FFFFF, 24'h000000, wall_ms);
        for (k = 0; k < 280; k++)
            send_beat(ACT_SAMPLE, COUNT_BITS'($urandom), 24'h000000, wall_ms);
        repeat (3) run_move();
        load_config(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                    16'h0000, 16'h0000, 16'h0000, 16'h0000);
        repeat (3) run_move();
        wait_drain();
    endtask

    // Hold the receiver off while moves keep coming, so the block backs up,
    // then let the sender wait for every result before going on.
    task automatic test_backpressure();
        set_idling(0, 0);
        random_config();
        hold_left <= 400;
        repeat (3) run_move();
        wait_drain();
        repeat (2) run_move();
        wait_drain();
    endtask

    // Random moves under each idle pattern, each with its own register set.
    task automatic test_idle_phases();
        int phase, goal_beats;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    set_idling(0, 0);
                    load_config(PROP_GAIN_RST, INTEG_GAIN_RST, INTEG_DECAY_RST,
                                16'(POWER_LIMIT_RST), SETTLE_BAND_RST, SETTLE_MS_RST,
                                WD_RATE_RST, WD_BASE_RST);
                end
                1:
                begin
                    set_idling(85, 0);
                    random_config();
                end
                2:
                begin
                    set_idling(0, 85);
                    random_config();
                end
                default:
                begin
                    set_idling(10, 10);
                    random_config();
                end
            endcase
            goal_beats = beats_sent + PHASE_BEATS;
            while (beats_sent < goal_beats)
                run_move();
        end
        wait_drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_register_extremes();
        test_backpressure();
        test_idle_phases();
        wait_drain();
        if (error_count == 0 && pending_drive.size() == 0)
            $display("encoder_move_pi_controller: match");
        else
            $display("encoder_move_pi_controller: mismatch");
        $finish;
    end

endmodule

[encoder_move_pi_controller.f]
src/empc_pkg.sv
src/empc_mul.sv
src/encoder_move_pi_controller.sv
test/testbench.sv
